FILE: design/gamepad_frame_encoder_defines.svh
// assertion macros shared by the gamepad frame encoder
`ifndef GAMEPAD_FRAME_ENCODER_DEFINES_SVH
`define GAMEPAD_FRAME_ENCODER_DEFINES_SVH

// consequent checked in the cycle after the antecedent
`define GFE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gamepad frame encoder check failed");

// consequent checked in the same cycle as the antecedent
`define GFE_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gamepad frame encoder check failed");

`endif

FILE: design/gfe_pkg.sv
// shared types, constants and decode functions for the gamepad frame encoder
package gfe_pkg;

   // stick scaling: exact reciprocal multiply, quotient taken from a fixed bit position
   localparam int unsigned RAW_W   = 10;
   localparam int unsigned MUL_W   = 17;
   localparam int unsigned PROD_W  = RAW_W + MUL_W;
   localparam int unsigned QUOT_W  = 6;
   localparam int unsigned STICK_W = 6;

   // x: d*100/1503 on the positive side, 2d/33 on the negative side, both over 2^20
   localparam logic [MUL_W-1:0] X_POS_MUL = 17'd69766;
   localparam logic [MUL_W-1:0] X_NEG_MUL = 17'd63552;
   localparam int unsigned      X_SHIFT   = 20;

   // y: 2d/31 on the positive side, 2d/33 on the negative side, both over 2^15
   localparam logic [MUL_W-1:0] Y_POS_MUL = 17'd2116;
   localparam logic [MUL_W-1:0] Y_NEG_MUL = 17'd1986;
   localparam int unsigned      Y_SHIFT   = 15;

   localparam logic [RAW_W-1:0]   RAW_CENTER = 10'd512;
   localparam logic [QUOT_W-1:0]  STICK_MAX  = 6'd31;

   // direction thresholds on the scaled stick
   localparam logic signed [STICK_W-1:0] STICK_EDGE_POS = 6'sd25;
   localparam logic signed [STICK_W-1:0] STICK_EDGE_NEG = -6'sd25;

   // frame byte offsets: 128+31 and 192+31
   localparam logic [7:0] X_BYTE_BASE = 8'd159;
   localparam logic [7:0] Y_BYTE_BASE = 8'd223;

   localparam logic [7:0] THROTTLE_MAX = 8'd255;
   localparam logic [7:0] THROTTLE_MIN = 8'd0;

   // quad frame slots
   localparam logic [1:0] SLOT_THROTTLE = 2'd0;
   localparam logic [1:0] SLOT_BUTTONS  = 2'd1;
   localparam logic [1:0] SLOT_STICK_X  = 2'd2;
   localparam logic [1:0] SLOT_STICK_Y  = 2'd3;

   // pad bit patterns
   localparam logic [3:0] PAD_UP         = 4'h1;
   localparam logic [3:0] PAD_UP_RIGHT   = 4'h9;
   localparam logic [3:0] PAD_RIGHT      = 4'h8;
   localparam logic [3:0] PAD_DOWN_RIGHT = 4'hA;
   localparam logic [3:0] PAD_DOWN       = 4'h2;
   localparam logic [3:0] PAD_DOWN_LEFT  = 4'h6;
   localparam logic [3:0] PAD_LEFT       = 4'h4;
   localparam logic [3:0] PAD_UP_LEFT    = 4'h5;

   typedef enum logic [3:0] {
      DIR_NONE       = 4'd0,
      DIR_UP         = 4'd1,
      DIR_UP_RIGHT   = 4'd2,
      DIR_RIGHT      = 4'd3,
      DIR_DOWN_RIGHT = 4'd4,
      DIR_DOWN       = 4'd5,
      DIR_DOWN_LEFT  = 4'd6,
      DIR_LEFT       = 4'd7,
      DIR_UP_LEFT    = 4'd8
   } dir_type;

   // direction from the pad buttons; unlisted combinations give none
   function automatic dir_type pad_dir(input logic [3:0] pad);
      dir_type dir;
      case (pad)
         PAD_UP:         dir = DIR_UP;
         PAD_UP_RIGHT:   dir = DIR_UP_RIGHT;
         PAD_RIGHT:      dir = DIR_RIGHT;
         PAD_DOWN_RIGHT: dir = DIR_DOWN_RIGHT;
         PAD_DOWN:       dir = DIR_DOWN;
         PAD_DOWN_LEFT:  dir = DIR_DOWN_LEFT;
         PAD_LEFT:       dir = DIR_LEFT;
         PAD_UP_LEFT:    dir = DIR_UP_LEFT;
         default:        dir = DIR_NONE;
      endcase
      return dir;
   endfunction

   // direction from the scaled stick, strict compares against the threshold
   function automatic dir_type stick_dir(input logic signed [STICK_W-1:0] x,
                                         input logic signed [STICK_W-1:0] y);
      logic    x_hi;
      logic    x_lo;
      logic    x_mid;
      logic    y_hi;
      logic    y_lo;
      logic    y_mid;
      dir_type dir;
      x_hi  = x > STICK_EDGE_POS;
      x_lo  = x < STICK_EDGE_NEG;
      x_mid = (x < STICK_EDGE_POS) && (x > STICK_EDGE_NEG);
      y_hi  = y > STICK_EDGE_POS;
      y_lo  = y < STICK_EDGE_NEG;
      y_mid = (y < STICK_EDGE_POS) && (y > STICK_EDGE_NEG);
      if (x_mid && y_hi) dir = DIR_UP;
      else if (x_hi && y_hi) dir = DIR_UP_RIGHT;
      else if (x_hi && y_mid) dir = DIR_RIGHT;
      else if (x_hi && y_lo) dir = DIR_DOWN_RIGHT;
      else if (x_mid && y_lo) dir = DIR_DOWN;
      else if (x_lo && y_lo) dir = DIR_DOWN_LEFT;
      else if (x_lo && y_mid) dir = DIR_LEFT;
      else if (x_lo && y_hi) dir = DIR_UP_LEFT;
      else dir = DIR_NONE;
      return dir;
   endfunction

endpackage

FILE: design/gfe_stick_scale.sv
// stick scaling: centre, divide by constant via reciprocal multiply, clamp to +/-31
module gfe_stick_scale (
   input  logic [gfe_pkg::RAW_W-1:0]          x_raw,
   input  logic [gfe_pkg::RAW_W-1:0]          y_raw,
   output logic signed [gfe_pkg::STICK_W-1:0] stick_x,
   output logic signed [gfe_pkg::STICK_W-1:0] stick_y
);

   logic                         x_pos;
   logic                         y_pos;
   logic [gfe_pkg::RAW_W-1:0]    x_mag;
   logic [gfe_pkg::RAW_W-1:0]    y_mag;
   logic [gfe_pkg::MUL_W-1:0]    x_mul;
   logic [gfe_pkg::MUL_W-1:0]    y_mul;
   logic [gfe_pkg::PROD_W-1:0]   x_prod;
   logic [gfe_pkg::PROD_W-1:0]   y_prod;
   logic [gfe_pkg::QUOT_W-1:0]   x_quot;
   logic [gfe_pkg::QUOT_W-1:0]   y_quot;
   logic [gfe_pkg::QUOT_W-1:0]   x_sat;
   logic [gfe_pkg::QUOT_W-1:0]   y_sat;

   // offset from centre as sign and magnitude; exact centre counts as the negative side
   assign x_pos = x_raw[gfe_pkg::RAW_W-1] & (|x_raw[gfe_pkg::RAW_W-2:0]);
   assign y_pos = y_raw[gfe_pkg::RAW_W-1] & (|y_raw[gfe_pkg::RAW_W-2:0]);
   assign x_mag = x_raw[gfe_pkg::RAW_W-1] ? {1'b0, x_raw[gfe_pkg::RAW_W-2:0]}
                                          : gfe_pkg::RAW_CENTER - x_raw;
   assign y_mag = y_raw[gfe_pkg::RAW_W-1] ? {1'b0, y_raw[gfe_pkg::RAW_W-2:0]}
                                          : gfe_pkg::RAW_CENTER - y_raw;

   // one multiplier per axis, reciprocal picked by side
   assign x_mul  = x_pos ? gfe_pkg::X_POS_MUL : gfe_pkg::X_NEG_MUL;
   assign y_mul  = y_pos ? gfe_pkg::Y_POS_MUL : gfe_pkg::Y_NEG_MUL;
   assign x_prod = {{gfe_pkg::MUL_W{1'b0}}, x_mag} * {{gfe_pkg::RAW_W{1'b0}}, x_mul};
   assign y_prod = {{gfe_pkg::MUL_W{1'b0}}, y_mag} * {{gfe_pkg::RAW_W{1'b0}}, y_mul};
   assign x_quot = x_prod[gfe_pkg::X_SHIFT +: gfe_pkg::QUOT_W];
   assign y_quot = y_prod[gfe_pkg::Y_SHIFT +: gfe_pkg::QUOT_W];

   // clamp magnitude
   assign x_sat = (x_quot > gfe_pkg::STICK_MAX) ? gfe_pkg::STICK_MAX : x_quot;
   assign y_sat = (y_quot > gfe_pkg::STICK_MAX) ? gfe_pkg::STICK_MAX : y_quot;

   // x is inverted: right of centre gives a negative value
   assign stick_x = x_pos ? (~x_sat + 6'd1) : x_sat;
   assign stick_y = y_pos ? y_sat : (~y_sat + 6'd1);

endmodule

FILE: design/gamepad_frame_encoder.sv
// top level of the gamepad frame encoder: input stage, frame logic, result stage
//
// Usage: one req_ beat per timer tick carries the stick readings and button
// flags; one rsp_ beat comes back for every req_ beat, in order, carrying the
// byte to transmit and the frame slot it belongs to.
// csr_wr_en with csr_wr_data selects quad frame mode (0) or pad mode (1);
// write it only while no beat is in flight.
// Path: an accepted beat is registered in the input stage, then computed and
// registered in the result stage once that stage can take it, which raises
// rsp_valid.
// Throughput: one beat per cycle while rsp_stall is low; in quad mode, throttle
// and slot update in the same cycle that a beat enters the result stage.
// Stall: while rsp_stall holds a full result stage, the input stage can still
// take one more beat; after that req_stall goes high until the result drains.
// Reset: clears both stages, the throttle, the frame slot and the mode (quad).
`include "gamepad_frame_encoder_defines.svh"

module gamepad_frame_encoder (
   input  logic       clock,
   input  logic       reset,
   // input channel
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [9:0] req_stick_x_raw,
   input  logic [9:0] req_stick_y_raw,
   input  logic [3:0] req_face_pressed,
   input  logic [3:0] req_shoulder_pressed,
   input  logic [3:0] req_pad_pressed,
   // result channel
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_tx_byte,
   output logic [1:0] rsp_slot,
   // configuration
   input  logic       csr_wr_en,
   input  logic       csr_wr_data
);

   // input stage
   logic       in_valid_ff;
   logic       in_valid_in;
   logic [9:0] in_x_ff;
   logic [9:0] in_y_ff;
   logic [3:0] in_face_ff;
   logic [3:0] in_shoulder_ff;
   logic [3:0] in_pad_ff;

   // result stage
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic [7:0] rsp_tx_byte_ff;
   logic [7:0] rsp_tx_byte_in;
   logic [1:0] rsp_slot_ff;
   logic [1:0] rsp_slot_in;

   // block state
   logic       pad_mode_ff;
   logic [7:0] throttle_ff;
   logic [7:0] throttle_in;
   logic [1:0] slot_ff;
   logic [1:0] slot_in;

   logic       out_ready;
   logic       in_ready;
   logic       req_take;
   logic       step;

   logic signed [gfe_pkg::STICK_W-1:0] stick_x;
   logic signed [gfe_pkg::STICK_W-1:0] stick_y;
   gfe_pkg::dir_type                   dir;
   logic [7:0]                         throttle_clr;
   logic [7:0]                         throttle_adj;
   logic [7:0]                         buttons;
   logic [7:0]                         quad_byte;

   // handshake
   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign in_ready  = !in_valid_ff || out_ready;
   assign req_take  = req_valid && in_ready;
   assign step      = in_valid_ff && out_ready;
   assign req_stall = !in_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_tx_byte = rsp_tx_byte_ff;
   assign rsp_slot  = rsp_slot_ff;

   assign in_valid_in  = in_ready ? req_valid : in_valid_ff;
   assign rsp_valid_in = out_ready ? in_valid_ff : rsp_valid_ff;

   // stick scaling
   gfe_stick_scale u_scale (
      .x_raw   (in_x_ff),
      .y_raw   (in_y_ff),
      .stick_x (stick_x),
      .stick_y (stick_y)
   );

   // pad mode direction: buttons win over the stick
   always_comb begin
      if (in_pad_ff != 4'h0) begin
         dir = gfe_pkg::pad_dir(in_pad_ff);
      end else begin
         dir = gfe_pkg::stick_dir(stick_x, stick_y);
      end
   end

   // throttle: x clears first, then even slots adjust with saturation
   always_comb begin
      throttle_clr = in_face_ff[2] ? gfe_pkg::THROTTLE_MIN : throttle_ff;
      throttle_adj = throttle_clr;
      if (!slot_ff[0]) begin
         if (in_face_ff[3]) begin
            throttle_adj = gfe_pkg::THROTTLE_MIN;
         end else if (in_shoulder_ff[1]) begin
            if (throttle_clr != gfe_pkg::THROTTLE_MAX) throttle_adj = throttle_clr + 8'd1;
         end else if (in_shoulder_ff[0]) begin
            if (throttle_clr != gfe_pkg::THROTTLE_MIN) throttle_adj = throttle_clr - 8'd1;
         end
      end
   end

   // button slot byte: 64 + L3 + R3 + throttle bit1 + X B A
   assign buttons = {1'b0, 1'b1, in_shoulder_ff[2], in_shoulder_ff[3],
                     throttle_clr[1], in_face_ff[2:0]};

   // quad slot byte
   always_comb begin
      case (slot_ff)
         gfe_pkg::SLOT_THROTTLE: quad_byte = {2'b00, throttle_adj[7:2]};
         gfe_pkg::SLOT_BUTTONS:  quad_byte = buttons;
         gfe_pkg::SLOT_STICK_X:  quad_byte = gfe_pkg::X_BYTE_BASE + {{2{stick_x[5]}}, stick_x};
         gfe_pkg::SLOT_STICK_Y:  quad_byte = gfe_pkg::Y_BYTE_BASE + {{2{stick_y[5]}}, stick_y};
         default:                quad_byte = buttons;
      endcase
   end

   // result and next state
   always_comb begin
      throttle_in    = throttle_ff;
      slot_in        = slot_ff;
      rsp_tx_byte_in = rsp_tx_byte_ff;
      rsp_slot_in    = rsp_slot_ff;
      if (step) begin
         if (pad_mode_ff) begin
            rsp_tx_byte_in = {in_face_ff, dir};
            rsp_slot_in    = gfe_pkg::SLOT_THROTTLE;
         end else begin
            rsp_tx_byte_in = quad_byte;
            rsp_slot_in    = slot_ff;
            throttle_in    = throttle_adj;
            slot_in        = slot_ff + 2'd1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pad_mode_ff  <= 1'b0;
         throttle_ff  <= gfe_pkg::THROTTLE_MIN;
         slot_ff      <= gfe_pkg::SLOT_THROTTLE;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         throttle_ff  <= throttle_in;
         slot_ff      <= slot_in;
         if (csr_wr_en) pad_mode_ff <= csr_wr_data;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_x_ff        <= req_stick_x_raw;
         in_y_ff        <= req_stick_y_raw;
         in_face_ff     <= req_face_pressed;
         in_shoulder_ff <= req_shoulder_pressed;
         in_pad_ff      <= req_pad_pressed;
      end
      rsp_tx_byte_ff <= rsp_tx_byte_in;
      rsp_slot_ff    <= rsp_slot_in;
   end

   // checks
   `GFE_ASSERT_NEXT(a_pad_slot_zero, clock, reset, step && pad_mode_ff, rsp_slot_ff == gfe_pkg::SLOT_THROTTLE)
   `GFE_ASSERT_NEXT(a_slot_advance, clock, reset, step && !pad_mode_ff, slot_ff == 2'($past(slot_ff) + 2'd1))
   `GFE_ASSERT_NEXT(a_throttle_hold, clock, reset, !step || pad_mode_ff, $stable(throttle_ff))
   `GFE_ASSERT_NEXT(a_button_marker, clock, reset, step && !pad_mode_ff && slot_ff == gfe_pkg::SLOT_BUTTONS, rsp_tx_byte_ff[7:6] == 2'b01)

endmodule
